// File: hdl/wsar_pkg.sv
// Shared constants, codes and control types of the selective-ack receiver.
`timescale 1ns / 1ps

package wsar_pkg;

  // Sizing
  localparam int MAX_WINDOW   = 32;
  localparam int RESEND_LIMIT = 3;
  localparam int WS_LIMIT     = (MAX_WINDOW < 32) ? MAX_WINDOW : 32;

  // Field widths
  localparam int WS_W   = 6;
  localparam int PT_W   = 24;
  localparam int RP_W   = 16;
  localparam int IDX_W  = 24;
  localparam int BM_W   = 32;
  localparam int OFF_W  = 5;
  localparam int CNT_W  = 2;
  localparam int BASE_W = IDX_W + WS_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_TOTAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESEND_PERIOD = 2'd2;

  localparam logic [WS_W-1:0] WS_RESET = 6'd32;
  localparam logic [PT_W-1:0] PT_RESET = 24'd1;
  localparam logic [RP_W-1:0] RP_RESET = 16'd10000;

  // Request codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_DATA  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_ACK    = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CMP,
    S_EXEC,
    S_OUT2
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic mul;
    logic cmp;
    logic exec;
    logic second;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic two;
  } dp_status_t;

endpackage

// File: hdl/wsar_ifs.sv
// Request and response channel interfaces of the selective-ack receiver.
`timescale 1ns / 1ps

interface wsar_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        already_current;
  logic [23:0] pack_index;
  logic        need_ack;

  modport source (output valid, req_type, already_current, pack_index, need_ack,
                  input ready);
  modport sink (input valid, req_type, already_current, pack_index, need_ack,
                output ready);
endinterface

interface wsar_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic        start_flag;
  logic [23:0] ack_window;
  logic [31:0] ack_bitmap;
  logic        last;

  modport source (output valid, result_kind, start_flag, ack_window, ack_bitmap, last,
                  input ready);
  modport sink (input valid, result_kind, start_flag, ack_window, ack_bitmap, last,
                output ready);
endinterface

// File: hdl/wsar_ctrl.sv
// Sequencer that steps each request word through multiply, compare and execute.
`timescale 1ns / 1ps

module wsar_ctrl import wsar_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (status.out_free) begin
          cmd.exec   = 1'b1;
          state_next = status.two ? S_OUT2 : S_IDLE;
        end
      end
      S_OUT2: begin
        if (status.out_free) begin
          cmd.second = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/wsar_dp.sv
// Datapath: configuration, window bookkeeping, resend timer and output register.
`timescale 1ns / 1ps

module wsar_dp import wsar_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            req_type,
  input  logic                  already_current,
  input  logic [IDX_W-1:0]      pack_index,
  input  logic                  need_ack,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  wsar_rsp_if.source            rsp
);

  // Configuration registers
  logic [WS_W-1:0] window_size;
  logic [PT_W-1:0] packet_total;
  logic [RP_W-1:0] resend_period;

  // Transfer state
  logic [BM_W-1:0]  recv_bitmap, recv_bitmap_next;
  logic [IDX_W-1:0] current_window, current_window_next;
  logic [IDX_W-1:0] saved_ack_window, saved_ack_window_next;
  logic [BM_W-1:0]  saved_ack_bitmap, saved_ack_bitmap_next;
  logic             resend_armed, resend_armed_next;
  logic [CNT_W-1:0] resend_count, resend_count_next;
  logic [RP_W-1:0]  tick_counter, tick_counter_next;
  logic             transfer_active, transfer_active_next;

  // Latched request word and intermediate results
  logic [1:0]        l_type;
  logic              l_have;
  logic [IDX_W-1:0]  l_idx;
  logic              l_need;
  logic [BASE_W-1:0] base;
  logic              lo_ok;
  logic [BASE_W-1:0] offset;
  logic [BASE_W-1:0] remain;

  // Output register
  logic             out_valid;
  logic [1:0]       out_kind;
  logic             out_flag;
  logic [IDX_W-1:0] out_win;
  logic [BM_W-1:0]  out_bm;
  logic             out_last;

  // Execute-stage signals
  logic             ws_ok, in_win, idx_ok, short_win, final_win;
  logic [WS_W-1:0]  n_expect;
  logic [BM_W-1:0]  mask, bm_set;
  logic [RP_W-1:0]  period, tick_inc;
  logic [CNT_W:0]   cnt_inc;
  logic             load;
  logic [1:0]       o_kind;
  logic             o_flag;
  logic [IDX_W-1:0] o_win;
  logic [BM_W-1:0]  o_bm;
  logic             o_last;

  assign status.out_free = !out_valid || rsp.ready;
  assign status.two      = (l_type == REQ_START) && !l_have;

  // Window checks on the registered compare results
  always_comb begin
    ws_ok     = (window_size != '0) && (window_size <= WS_W'(WS_LIMIT));
    in_win    = lo_ok && (offset < BASE_W'(window_size));
    idx_ok    = l_idx < packet_total;
    bm_set    = recv_bitmap | (BM_W'(1) << offset[OFF_W-1:0]);
    short_win = remain < BASE_W'(window_size);
    final_win = remain <= BASE_W'(window_size);
    n_expect  = short_win ? remain[WS_W-1:0] : window_size;
    mask      = (n_expect >= WS_W'(BM_W)) ? '1 : ((BM_W'(1) << n_expect) - BM_W'(1));
    period    = (resend_period == '0) ? RP_W'(1) : resend_period;
    tick_inc  = tick_counter + RP_W'(1);
    cnt_inc   = {1'b0, resend_count} + (CNT_W+1)'(1);
  end

  // Execute one request word
  always_comb begin
    recv_bitmap_next      = recv_bitmap;
    current_window_next   = current_window;
    saved_ack_window_next = saved_ack_window;
    saved_ack_bitmap_next = saved_ack_bitmap;
    resend_armed_next     = resend_armed;
    resend_count_next     = resend_count;
    tick_counter_next     = tick_counter;
    transfer_active_next  = transfer_active;
    load   = 1'b0;
    o_kind = KIND_REJECT;
    o_flag = 1'b0;
    o_win  = '0;
    o_bm   = '0;
    o_last = 1'b1;
    case (l_type)
      REQ_START: begin
        // Clear everything; a fresh download also arms the window-0 ack
        recv_bitmap_next      = '0;
        current_window_next   = '0;
        saved_ack_window_next = '0;
        saved_ack_bitmap_next = '0;
        resend_count_next     = '0;
        tick_counter_next     = '0;
        transfer_active_next  = !l_have;
        resend_armed_next     = !l_have;
        load   = 1'b1;
        o_kind = KIND_START;
        o_flag = l_have;
        o_last = l_have;
      end
      REQ_DATA: begin
        if (!transfer_active || !ws_ok) begin
          load = 1'b1;
        end else begin
          resend_armed_next = 1'b0;
          if (!idx_ok || !in_win) begin
            load = 1'b1;
          end else begin
            recv_bitmap_next = bm_set;
            if (l_need) begin
              load = 1'b1;
              if (bm_set == mask) begin
                if (final_win) begin
                  // Transfer complete: report and drop back to idle
                  o_kind = KIND_DONE;
                  o_win  = current_window;
                  o_bm   = bm_set;
                  recv_bitmap_next      = '0;
                  current_window_next   = '0;
                  saved_ack_window_next = '0;
                  saved_ack_bitmap_next = '0;
                  resend_count_next     = '0;
                  tick_counter_next     = '0;
                  transfer_active_next  = 1'b0;
                end else begin
                  // Advance to the next window and ack it empty
                  current_window_next   = current_window + IDX_W'(1);
                  recv_bitmap_next      = '0;
                  o_kind                = KIND_ACK;
                  o_win                 = current_window + IDX_W'(1);
                  saved_ack_window_next = current_window + IDX_W'(1);
                  saved_ack_bitmap_next = '0;
                  resend_armed_next     = 1'b1;
                  resend_count_next     = '0;
                  tick_counter_next     = '0;
                end
              end else begin
                o_kind                = KIND_ACK;
                o_win                 = current_window;
                o_bm                  = bm_set;
                saved_ack_window_next = current_window;
                saved_ack_bitmap_next = bm_set;
                resend_armed_next     = 1'b1;
                resend_count_next     = '0;
                tick_counter_next     = '0;
              end
            end
          end
        end
      end
      REQ_TICK: begin
        if (resend_armed) begin
          tick_counter_next = tick_inc;
          if (tick_inc >= period) begin
            tick_counter_next = '0;
            load   = 1'b1;
            o_kind = KIND_ACK;
            o_win  = saved_ack_window;
            o_bm   = saved_ack_bitmap;
            resend_count_next = cnt_inc[CNT_W-1:0];
            if (cnt_inc >= (CNT_W+1)'(RESEND_LIMIT)) begin
              resend_armed_next = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size      <= WS_RESET;
      packet_total     <= PT_RESET;
      resend_period    <= RP_RESET;
      recv_bitmap      <= '0;
      current_window   <= '0;
      saved_ack_window <= '0;
      saved_ack_bitmap <= '0;
      resend_armed     <= 1'b0;
      resend_count     <= '0;
      tick_counter     <= '0;
      transfer_active  <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      // Take configuration writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_SIZE:   window_size   <= cfg_data[WS_W-1:0];
          CFG_PACKET_TOTAL:  packet_total  <= cfg_data[PT_W-1:0];
          CFG_RESEND_PERIOD: resend_period <= cfg_data[RP_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.exec) begin
        recv_bitmap      <= recv_bitmap_next;
        current_window   <= current_window_next;
        saved_ack_window <= saved_ack_window_next;
        saved_ack_bitmap <= saved_ack_bitmap_next;
        resend_armed     <= resend_armed_next;
        resend_count     <= resend_count_next;
        tick_counter     <= tick_counter_next;
        transfer_active  <= transfer_active_next;
      end
      // Hold the result word until it is taken
      if ((cmd.exec && load) || cmd.second) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      l_type <= req_type;
      l_have <= already_current;
      l_idx  <= pack_index;
      l_need <= need_ack;
    end
    if (cmd.mul) begin
      base <= BASE_W'(current_window) * BASE_W'(window_size);
    end
    if (cmd.cmp) begin
      lo_ok  <= BASE_W'(l_idx) >= base;
      offset <= BASE_W'(l_idx) - base;
      remain <= BASE_W'(packet_total) - base;
    end
    if (cmd.exec && load) begin
      out_kind <= o_kind;
      out_flag <= o_flag;
      out_win  <= o_win;
      out_bm   <= o_bm;
      out_last <= o_last;
    end else if (cmd.second) begin
      out_kind <= KIND_ACK;
      out_flag <= 1'b0;
      out_win  <= '0;
      out_bm   <= '0;
      out_last <= 1'b1;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_kind;
  assign rsp.start_flag  = out_flag;
  assign rsp.ack_window  = out_win;
  assign rsp.ack_bitmap  = out_bm;
  assign rsp.last        = out_last;

  // A pending word is never overwritten
  a_exec_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec || cmd.second) |-> (!out_valid || rsp.ready))
    else $error("result word overwritten while pending");

  // The timer only runs during an active transfer
  a_armed_active: assert property (@(posedge clk) disable iff (rst)
    resend_armed |-> transfer_active)
    else $error("resend timer armed while idle");

  // The second start word closes the reply
  a_second_last: assert property (@(posedge clk) disable iff (rst)
    cmd.second |=> (out_valid && out_last && out_kind == KIND_ACK))
    else $error("second start word malformed");

endmodule

// File: hdl/windowed_selective_ack_receiver.sv
// Top level of the windowed selective-ack receiver.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    req_type, already_current, pack_index, need_ack
//   rsp      out  valid/ready    result_kind, start_flag, ack_window, ack_bitmap, last
//   cfg      in   cfg_we         cfg_index, cfg_data
//
// A request word passes through accept, window base multiply, window
// compare and execute; a start that opens a download adds a step for
// its second reply word. The execute step waits while the single output
// register still holds an untaken word. Synchronous reset clears the
// window state, the timer and the output register and reloads the
// configuration defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module windowed_selective_ack_receiver import wsar_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  wsar_req_if.sink              req,
  wsar_rsp_if.source            rsp
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign req.ready = in_ready;

  // Sequencer
  wsar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  wsar_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_type        (req.req_type),
    .already_current (req.already_current),
    .pack_index      (req.pack_index),
    .need_ack        (req.need_ack),
    .cmd             (cmd),
    .status          (status),
    .rsp             (rsp)
  );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the windowed selective-ack receiver.
`timescale 1ns / 1ps

module tb;
  import wsar_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_WORDS   = 1900;

  typedef struct packed {
    logic [1:0]       req_type;
    logic             already_current;
    logic [IDX_W-1:0] pack_index;
    logic             need_ack;
  } req_word_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic             start_flag;
    logic [IDX_W-1:0] ack_window;
    logic [BM_W-1:0]  ack_bitmap;
    logic             last;
  } reply_t;

  // Window bookkeeping of the receiver and the replies it still owes
  class sack_scoreboard;
    logic [WS_W-1:0]  window_size;
    logic [PT_W-1:0]  packet_total;
    logic [RP_W-1:0]  resend_period;
    logic [BM_W-1:0]  recv_bitmap;
    logic [IDX_W-1:0] cur_window;
    logic [IDX_W-1:0] pkt_count;
    logic [IDX_W-1:0] saved_window;
    logic [BM_W-1:0]  saved_bitmap;
    logic             armed;
    logic             active;
    logic [CNT_W-1:0] resend_count;
    logic [RP_W-1:0]  tick_count;
    reply_t           owed[$];
    reply_t           batch[$];
    int               errors;

    function new();
      window_size   = WS_RESET;
      packet_total  = PT_RESET;
      resend_period = RP_RESET;
      errors        = 0;
      clear_window();
    endfunction

    function void clear_window();
      recv_bitmap  = '0;
      cur_window   = '0;
      pkt_count    = '0;
      saved_window = '0;
      saved_bitmap = '0;
      armed        = 1'b0;
      resend_count = '0;
      tick_count   = '0;
      active       = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WINDOW_SIZE:   window_size   = data[WS_W-1:0];
        CFG_PACKET_TOTAL:  packet_total  = data[PT_W-1:0];
        CFG_RESEND_PERIOD: resend_period = data[RP_W-1:0];
        default: ;
      endcase
    endfunction

    function void emit(logic [1:0] kind, logic flag, logic [IDX_W-1:0] win,
                       logic [BM_W-1:0] bm);
      reply_t r;
      r.result_kind = kind;
      r.start_flag  = flag;
      r.ack_window  = win;
      r.ack_bitmap  = bm;
      r.last        = 1'b0;
      batch.push_back(r);
    endfunction

    // Send an ack and arm the resend timer with it
    function void send_ack(logic [IDX_W-1:0] win, logic [BM_W-1:0] bm);
      emit(KIND_ACK, 1'b0, win, bm);
      saved_window = win;
      saved_bitmap = bm;
      armed        = 1'b1;
      resend_count = '0;
      tick_count   = '0;
    endfunction

    function void receive_packet(logic [IDX_W-1:0] idx, logic need);
      int unsigned ws, base, remain, n, ix;
      logic [BM_W:0] mask;
      ws = 32'(window_size);
      ix = 32'(idx);
      if (!active || ws == 0 || ws > WS_LIMIT) begin
        emit(KIND_REJECT, 1'b0, '0, '0);
        return;
      end
      armed = 1'b0;
      if (idx >= packet_total || ix / ws != 32'(cur_window)) begin
        emit(KIND_REJECT, 1'b0, '0, '0);
        return;
      end
      recv_bitmap |= BM_W'(1) << (ix % ws);
      if (pkt_count != '1) pkt_count++;
      if (!need) return;
      base   = 32'(cur_window) * ws;
      remain = 32'(packet_total) - base;
      n      = (remain < ws) ? remain : ws;
      mask   = ((BM_W+1)'(1) << n) - (BM_W+1)'(1);
      if (recv_bitmap == mask[BM_W-1:0]) begin
        if (remain <= ws) begin
          emit(KIND_DONE, 1'b0, cur_window, recv_bitmap);
          clear_window();
        end else begin
          cur_window  = cur_window + 1'b1;
          recv_bitmap = '0;
          send_ack(cur_window, '0);
        end
      end else begin
        send_ack(cur_window, recv_bitmap);
      end
    endfunction

    function void count_tick();
      logic [RP_W-1:0] period;
      if (!armed) return;
      period = (resend_period == '0) ? RP_W'(1) : resend_period;
      tick_count = tick_count + 1'b1;
      if (tick_count < period) return;
      tick_count = '0;
      emit(KIND_ACK, 1'b0, saved_window, saved_bitmap);
      resend_count = resend_count + 1'b1;
      if (resend_count >= CNT_W'(RESEND_LIMIT)) armed = 1'b0;
    endfunction

    // Work out the replies of one accepted request word
    function void take_request(req_word_t w);
      batch.delete();
      case (w.req_type)
        REQ_START: begin
          clear_window();
          emit(KIND_START, w.already_current, '0, '0);
          if (!w.already_current) begin
            active = 1'b1;
            send_ack('0, '0);
          end
        end
        REQ_DATA: receive_packet(w.pack_index, w.need_ack);
        REQ_TICK: count_tick();
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) owed.push_back(batch[i]);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected reply: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
      check_field("start_flag", 32'(want.start_flag), 32'(got.start_flag));
      check_field("ack_window", 32'(want.ack_window), 32'(got.ack_window));
      check_field("ack_bitmap", want.ack_bitmap, got.ack_bitmap);
      check_field("last", 32'(want.last), 32'(got.last));
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wsar_req_if req_ch ();
  wsar_rsp_if rsp_ch ();

  windowed_selective_ack_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  sack_scoreboard sb = new();

  int burst_left = 0;
  int gap_max    = 0;
  bit hold_req   = 1'b0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check every reply word taken from the block
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_reply({rsp_ch.result_kind, rsp_ch.start_flag, rsp_ch.ack_window,
                      rsp_ch.ack_bitmap, rsp_ch.last});
    end
  end

  // End the run when no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d replies owed", $time, sb.pending());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Drive ready on a shifting stall pattern, with one long hold on request
  initial begin
    int cnt;
    cnt = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      case ((cnt / 97) % 4)
        0: rsp_ch.ready = 1'b1;
        1: rsp_ch.ready = 1'($urandom_range(0, 1));
        2: rsp_ch.ready = ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready = ((cnt % 16) < 10);
      endcase
      cnt++;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(logic [WS_W-1:0] ws, logic [PT_W-1:0] total,
                            logic [RP_W-1:0] period);
    write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(ws));
    write_reg(CFG_PACKET_TOTAL, CFG_DATA_W'(total));
    write_reg(CFG_RESEND_PERIOD, CFG_DATA_W'(period));
  endtask

  // Offer one request word in bursts with random gaps; hold until taken
  task automatic send_word(req_word_t w);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        req_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    req_ch.valid           = 1'b1;
    req_ch.req_type        = w.req_type;
    req_ch.already_current = w.already_current;
    req_ch.pack_index      = w.pack_index;
    req_ch.need_ack        = w.need_ack;
    do @(posedge clk); while (!req_ch.ready);
    sb.take_request(w);
  endtask

  task automatic send_req(logic [1:0] t, logic have, logic [IDX_W-1:0] idx, logic need);
    send_word({t, have, idx, need});
  endtask

  // Drop valid and wait until every owed reply is back and the block is idle
  task automatic settle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Pick the next word: mostly packets that fill the current window
  task automatic build_word(output req_word_t w);
    int ws, base, n, off, r;
    logic [BM_W-1:0] missing;
    logic in_window;
    ws = int'(sb.window_size);
    w.req_type        = REQ_TICK;
    w.already_current = 1'($urandom_range(0, 1));
    w.pack_index      = IDX_W'($urandom());
    w.need_ack        = 1'($urandom_range(0, 1));
    n = 0;
    base = 0;
    in_window = 1'b0;
    if (sb.active && ws != 0 && ws <= WS_LIMIT) begin
      base = int'(sb.cur_window) * ws;
      if (base < int'(sb.packet_total)) begin
        n = int'(sb.packet_total) - base;
        if (n > ws) n = ws;
        in_window = 1'b1;
      end
    end
    r = $urandom_range(0, 99);
    if (!in_window && r < 60) begin
      w.req_type        = REQ_START;
      w.already_current = ($urandom_range(0, 9) == 0);
    end else if (in_window && r < 72) begin
      missing = ~sb.recv_bitmap & BM_W'(((BM_W+1)'(1) << n) - (BM_W+1)'(1));
      w.req_type = REQ_DATA;
      if (missing == '0) begin
        off = $urandom_range(0, n - 1);
        w.need_ack = 1'b1;
      end else begin
        do off = $urandom_range(0, n - 1); while (!missing[off]);
        if ($countones(missing) == 1) w.need_ack = ($urandom_range(0, 9) != 0);
        else w.need_ack = ($urandom_range(0, 3) == 0);
      end
      w.pack_index = IDX_W'(base + off);
    end else if (r < 84) begin
      w.req_type = REQ_TICK;
    end else if (r < 90 && in_window) begin
      // a packet of the current window, received or not
      w.req_type   = REQ_DATA;
      w.pack_index = IDX_W'(base + $urandom_range(0, n - 1));
    end else if (r < 96) begin
      w.req_type = REQ_DATA;
    end else if (r < 98) begin
      w.req_type = REQ_START;
    end else begin
      w.req_type = REQ_UNUSED;
    end
  endtask

  initial begin
    req_word_t w;
    int words_done, phase, len, k, ws_eff, pick;
    logic [WS_W-1:0]  ws;
    logic [PT_W-1:0]  total;
    logic [RP_W-1:0]  period;
    logic             ignored;

    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    req_ch.valid           = 1'b0;
    req_ch.req_type        = REQ_START;
    req_ch.already_current = 1'b0;
    req_ch.pack_index      = '0;
    req_ch.need_ack        = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: idle rejects, start replies, a one-packet transfer on defaults
    gap_max = 3;
    send_req(REQ_DATA, 1'b0, '0, 1'b1);
    send_req(REQ_START, 1'b1, '0, 1'b0);
    send_req(REQ_DATA, 1'b0, '0, 1'b1);
    send_req(REQ_UNUSED, 1'b1, '1, 1'b1);
    send_req(REQ_TICK, 1'b0, '0, 1'b0);
    send_req(REQ_START, 1'b0, '0, 1'b0);
    send_req(REQ_TICK, 1'b0, '0, 1'b0);
    send_req(REQ_DATA, 1'b0, '0, 1'b1);
    settle();

    // Directed: short last window, wrong window, index past total, resends
    set_config(6'd4, 24'd10, 16'd1);
    send_req(REQ_START, 1'b0, '0, 1'b0);
    send_req(REQ_DATA, 1'b0, 24'd5, 1'b1);
    send_req(REQ_DATA, 1'b0, '1, 1'b1);
    send_req(REQ_DATA, 1'b0, 24'd1, 1'b0);
    send_req(REQ_DATA, 1'b0, 24'd0, 1'b1);
    repeat (4) send_req(REQ_TICK, 1'b0, '0, 1'b0);
    send_req(REQ_DATA, 1'b0, 24'd2, 1'b0);
    send_req(REQ_DATA, 1'b0, 24'd3, 1'b1);
    for (k = 4; k < 10; k++) send_req(REQ_DATA, 1'b0, IDX_W'(k), (k >= 7));
    settle();

    // Directed: window sizes of zero and above the limit, period of zero
    set_config(6'd0, 24'hFFFFFF, 16'd0);
    send_req(REQ_START, 1'b0, '0, 1'b0);
    send_req(REQ_DATA, 1'b0, '0, 1'b1);
    send_req(REQ_TICK, 1'b0, '0, 1'b0);
    settle();
    write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(6'd63));
    send_req(REQ_DATA, 1'b0, '0, 1'b1);
    settle();

    // Random phases, each with a fresh setting of all registers
    words_done = 0;
    phase = 0;
    while (words_done < RANDOM_WORDS) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0: ws = 6'd0;
        1: ws = WS_W'($urandom_range(WS_LIMIT + 1, 63));
        2: ws = 6'd1;
        3: ws = 6'd32;
        default: ws = WS_W'($urandom_range(1, WS_LIMIT));
      endcase
      ws_eff = (ws != 0 && ws <= WS_LIMIT) ? int'(ws) : 8;
      pick = $urandom_range(0, 19);
      case (pick)
        0: total = 24'hFFFFFF;
        1: total = 24'd0;
        2: total = PT_W'($urandom());
        default: total = PT_W'($urandom_range(1, ws_eff * 6));
      endcase
      pick = $urandom_range(0, 19);
      case (pick)
        0: period = 16'd0;
        1: period = 16'hFFFF;
        2: period = RP_W'($urandom_range(5, 300));
        default: period = RP_W'($urandom_range(1, 4));
      endcase
      set_config(ws, total, period);

      gap_max = (phase % 4 == 0) ? 0 : $urandom_range(1, 12);
      if (phase == 2) begin
        hold_req = 1'b1;
        gap_max  = 0;
      end
      len = $urandom_range(40, 140);
      send_req(REQ_START, 1'b0, IDX_W'($urandom()), 1'($urandom_range(0, 1)));
      for (k = 0; k < len; k++) begin
        // pause the sender until every owed reply is back
        if (phase == 3 && k == len / 2) begin
          @(negedge clk);
          req_ch.valid = 1'b0;
          while (sb.pending() != 0) @(negedge clk);
        end
        build_word(w);
        ignored = (w.req_type == REQ_UNUSED) || (w.req_type == REQ_TICK && !sb.armed);
        send_word(w);
        if (!ignored) words_done++;
      end
      settle();
      phase++;
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
